// ===== src/modem_alert_call_sequencer_macros.svh =====
// Assertion macros for the modem alert call sequencer checker.
`ifndef MODEM_ALERT_CALL_SEQUENCER_MACROS_SVH
`define MODEM_ALERT_CALL_SEQUENCER_MACROS_SVH

// Same-cycle implication, sampled on clk, idle during reset.
`define MCS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, idle during reset.
`define MCS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/mcs_pkg.sv =====
// Shared types, codes, register defaults and token matcher for the alert sequencer.
package mcs_pkg;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_STARTING,
		PH_AT_INIT,
		PH_CMGF,
		PH_SMS_CMD,
		PH_BODY,
		PH_WAIT_SMS,
		PH_PRE_CALL,
		PH_MAKE_CALL,
		PH_IN_CALL,
		PH_FINISHED,
		PH_CLEANUP
	} phase_t;

	typedef enum logic [3:0] {
		CMD_NONE        = 4'd0,
		CMD_OPEN_MODEM  = 4'd1,
		CMD_AT          = 4'd2,
		CMD_TEXT_MODE   = 4'd3,
		CMD_SMS_HEADER  = 4'd4,
		CMD_BODY        = 4'd5,
		CMD_HANGUP      = 4'd6,
		CMD_DIAL        = 4'd7,
		CMD_CLOSE_UART  = 4'd8,
		CMD_OPEN_GPS    = 4'd9
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_TICK    = 2'd0,
		KIND_BYTE    = 2'd1,
		KIND_TRIGGER = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		REG_UART_SETTLE  = 3'd0,
		REG_AT_TIMEOUT   = 3'd1,
		REG_AT_RETRIES   = 3'd2,
		REG_PROMPT_TO    = 3'd3,
		REG_SMS_TO       = 3'd4,
		REG_HANGUP_DELAY = 3'd5,
		REG_DIAL_DELAY   = 3'd6,
		REG_CALL_TIME    = 3'd7
	} reg_idx_t;

	localparam int unsigned MS_W   = 16;
	localparam int unsigned CFG_W  = 16;
	localparam int unsigned RETRY_W = 3;

	localparam logic [MS_W-1:0]    RST_UART_SETTLE  = 16'd100;
	localparam logic [MS_W-1:0]    RST_AT_TIMEOUT   = 16'd2000;
	localparam logic [RETRY_W-1:0] RST_AT_RETRIES   = 3'd3;
	localparam logic [MS_W-1:0]    RST_PROMPT_TO    = 16'd3000;
	localparam logic [MS_W-1:0]    RST_SMS_TO       = 16'd15000;
	localparam logic [MS_W-1:0]    RST_HANGUP_DELAY = 16'd300;
	localparam logic [MS_W-1:0]    RST_DIAL_DELAY   = 16'd600;
	localparam logic [MS_W-1:0]    RST_CALL_TIME    = 16'd30000;

	// reply tokens, padded to eight characters
	localparam logic [7:0] TOK_OK   [8] = '{8'h4F, 8'h4B, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00};
	localparam logic [7:0] TOK_CMGS [8] = '{8'h2B, 8'h43, 8'h4D, 8'h47,
		8'h53, 8'h3A, 8'h00, 8'h00};
	localparam logic [7:0] TOK_ERR  [8] = '{8'h45, 8'h52, 8'h52, 8'h4F,
		8'h52, 8'h00, 8'h00, 8'h00};
	localparam logic [2:0] LEN_OK   = 3'd2;
	localparam logic [2:0] LEN_CMGS = 3'd6;
	localparam logic [2:0] LEN_ERR  = 3'd5;
	localparam logic [7:0] CHR_PROMPT = 8'h3E;

	localparam logic [3:0] FLG_OK     = 4'b0001;
	localparam logic [3:0] FLG_PROMPT = 4'b0010;
	localparam logic [3:0] FLG_CMGS   = 4'b0100;
	localparam logic [3:0] FLG_ERROR  = 4'b1000;

	// result word, command in the lowest bits
	typedef struct packed {
		logic sms_confirmed;
		logic busy_res;
		logic body_custom;
		logic body_position;
		cmd_t command;
	} out_word_t;

	typedef struct packed {
		logic      push;
		logic      two;
		out_word_t w0;
		out_word_t w1;
	} push_t;

	// advance one streaming matcher: {hit, next progress}
	function automatic logic [3:0] tok_step(input logic [7:0] t [8], input logic [2:0] len,
		input logic [2:0] p, input logic [7:0] c);
		logic [2:0] q;
		logic [2:0] nx;
		logic [2:0] np;
		logic       hit;
		q = (p >= len) ? 3'd0 : p;
		nx = q + 3'd1;
		hit = 1'b0;
		if (c == t[q]) begin
			if (nx == len) begin
				hit = 1'b1;
				np = 3'd0;
			end else begin
				np = nx;
			end
		end else begin
			np = (c == t[0]) ? 3'd1 : 3'd0;
		end
		return {hit, np};
	endfunction

endpackage

// ===== src/mcs_core.sv =====
// Input register, configuration registers and the per-word sequencer update.
module mcs_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [15:0]           cfg_wdata,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [9:0]            s_tdata,
	input  logic [1:0]            s_tuser,
	input  logic                  room,
	output mcs_pkg::push_t        push
);

	logic                  valid_s1;
	logic [1:0]            kind_s1;
	logic [7:0]            byte_s1;
	logic                  pos_s1;
	logic                  cus_s1;

	logic [15:0]           settle_q, at_to_q, prompt_to_q, sms_to_q;
	logic [15:0]           hangup_q, dial_q, call_q;
	logic [2:0]            retries_q;

	mcs_pkg::phase_t       phase_q, phase_d;
	logic [15:0]           ms_q, ms_d, ms_inc, wait_lim;
	logic [2:0]            att_q, att_d, att_inc;
	logic                  sms_q, sms_d, pos_q, pos_d, cus_q, cus_d;
	logic [3:0]            flags_q, flags_d;
	logic                  pok_q, pok_d;
	logic [2:0]            pcm_q, pcm_d, per_q, per_d;
	logic [3:0]            r_ok, r_cm, r_er;
	logic                  timed_out, fire, accept;
	logic                  emit0, emit1;
	mcs_pkg::cmd_t         cmd0, cmd1;

	assign fire     = valid_s1 & room;
	assign s_tready = ~valid_s1 | room;
	assign accept   = s_tvalid & s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= s_tuser;
			byte_s1 <= s_tdata[7:0];
			pos_s1  <= s_tdata[8];
			cus_s1  <= s_tdata[9];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q    <= mcs_pkg::RST_UART_SETTLE;
			at_to_q     <= mcs_pkg::RST_AT_TIMEOUT;
			retries_q   <= mcs_pkg::RST_AT_RETRIES;
			prompt_to_q <= mcs_pkg::RST_PROMPT_TO;
			sms_to_q    <= mcs_pkg::RST_SMS_TO;
			hangup_q    <= mcs_pkg::RST_HANGUP_DELAY;
			dial_q      <= mcs_pkg::RST_DIAL_DELAY;
			call_q      <= mcs_pkg::RST_CALL_TIME;
		end else if (cfg_we) begin
			unique case (mcs_pkg::reg_idx_t'(cfg_index))
				mcs_pkg::REG_UART_SETTLE:  settle_q    <= cfg_wdata;
				mcs_pkg::REG_AT_TIMEOUT:   at_to_q     <= cfg_wdata;
				mcs_pkg::REG_AT_RETRIES:   retries_q   <= cfg_wdata[2:0];
				mcs_pkg::REG_PROMPT_TO:    prompt_to_q <= cfg_wdata;
				mcs_pkg::REG_SMS_TO:       sms_to_q    <= cfg_wdata;
				mcs_pkg::REG_HANGUP_DELAY: hangup_q    <= cfg_wdata;
				mcs_pkg::REG_DIAL_DELAY:   dial_q      <= cfg_wdata;
				mcs_pkg::REG_CALL_TIME:    call_q      <= cfg_wdata;
				default:                   settle_q    <= settle_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= mcs_pkg::PH_IDLE;
			ms_q    <= '0;
			att_q   <= '0;
			sms_q   <= 1'b0;
			pos_q   <= 1'b0;
			cus_q   <= 1'b0;
			flags_q <= '0;
			pok_q   <= 1'b0;
			pcm_q   <= '0;
			per_q   <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			ms_q    <= ms_d;
			att_q   <= att_d;
			sms_q   <= sms_d;
			pos_q   <= pos_d;
			cus_q   <= cus_d;
			flags_q <= flags_d;
			pok_q   <= pok_d;
			pcm_q   <= pcm_d;
			per_q   <= per_d;
		end
	end

	assign ms_inc  = (ms_q == 16'hFFFF) ? ms_q : ms_q + 16'd1;
	assign att_inc = (att_q == 3'd7) ? att_q : att_q + 3'd1;

	always_comb begin
		case (phase_q)
			mcs_pkg::PH_AT_INIT, mcs_pkg::PH_SMS_CMD: wait_lim = at_to_q;
			mcs_pkg::PH_BODY:      wait_lim = prompt_to_q;
			mcs_pkg::PH_WAIT_SMS:  wait_lim = sms_to_q;
			mcs_pkg::PH_PRE_CALL:  wait_lim = hangup_q;
			mcs_pkg::PH_MAKE_CALL: wait_lim = dial_q;
			mcs_pkg::PH_IN_CALL:   wait_lim = call_q;
			default:               wait_lim = settle_q;
		endcase
	end

	assign timed_out = ms_inc > wait_lim;

	assign r_ok = mcs_pkg::tok_step(mcs_pkg::TOK_OK, mcs_pkg::LEN_OK, {2'b00, pok_q}, byte_s1);
	assign r_cm = mcs_pkg::tok_step(mcs_pkg::TOK_CMGS, mcs_pkg::LEN_CMGS, pcm_q, byte_s1);
	assign r_er = mcs_pkg::tok_step(mcs_pkg::TOK_ERR, mcs_pkg::LEN_ERR, per_q, byte_s1);

	always_comb begin
		phase_d = phase_q;
		ms_d    = ms_q;
		att_d   = att_q;
		sms_d   = sms_q;
		pos_d   = pos_q;
		cus_d   = cus_q;
		flags_d = flags_q;
		pok_d   = pok_q;
		pcm_d   = pcm_q;
		per_d   = per_q;
		emit0   = 1'b0;
		emit1   = 1'b0;
		cmd0    = mcs_pkg::CMD_NONE;
		cmd1    = mcs_pkg::CMD_NONE;
		case (kind_s1)
			mcs_pkg::KIND_TICK: begin
				if (phase_q != mcs_pkg::PH_IDLE) begin
					ms_d = ms_inc;
					unique case (phase_q)
						mcs_pkg::PH_STARTING: begin
							if (timed_out) begin
								emit0 = 1'b1;
								cmd0  = mcs_pkg::CMD_OPEN_MODEM;
								emit1 = 1'b1;
								cmd1  = mcs_pkg::CMD_AT;
								phase_d = mcs_pkg::PH_AT_INIT;
							end
						end
						mcs_pkg::PH_AT_INIT: begin
							if ((flags_q & mcs_pkg::FLG_OK) != '0) begin
								phase_d = mcs_pkg::PH_CMGF;
							end else if (timed_out) begin
								att_d = att_inc;
								if (att_inc >= retries_q) begin
									phase_d = mcs_pkg::PH_CMGF;
								end else begin
									emit0 = 1'b1;
									cmd0  = mcs_pkg::CMD_AT;
									phase_d = mcs_pkg::PH_AT_INIT;
								end
							end
						end
						mcs_pkg::PH_CMGF: begin
							if (timed_out) begin
								emit0 = 1'b1;
								cmd0  = mcs_pkg::CMD_TEXT_MODE;
								phase_d = mcs_pkg::PH_SMS_CMD;
							end
						end
						mcs_pkg::PH_SMS_CMD: begin
							if (((flags_q & mcs_pkg::FLG_OK) != '0) || timed_out) begin
								emit0 = 1'b1;
								cmd0  = mcs_pkg::CMD_SMS_HEADER;
								phase_d = mcs_pkg::PH_BODY;
							end
						end
						mcs_pkg::PH_BODY: begin
							if (((flags_q & mcs_pkg::FLG_PROMPT) != '0) || timed_out) begin
								emit0 = 1'b1;
								cmd0  = mcs_pkg::CMD_BODY;
								cus_d = 1'b0;
								phase_d = mcs_pkg::PH_WAIT_SMS;
							end
						end
						mcs_pkg::PH_WAIT_SMS: begin
							if ((flags_q & (mcs_pkg::FLG_CMGS | mcs_pkg::FLG_OK)) != '0) begin
								sms_d = 1'b1;
								phase_d = mcs_pkg::PH_PRE_CALL;
							end else if (((flags_q & mcs_pkg::FLG_ERROR) != '0) || timed_out) begin
								phase_d = mcs_pkg::PH_PRE_CALL;
							end
						end
						mcs_pkg::PH_PRE_CALL: begin
							if (timed_out) begin
								emit0 = 1'b1;
								cmd0  = mcs_pkg::CMD_HANGUP;
								phase_d = mcs_pkg::PH_MAKE_CALL;
							end
						end
						mcs_pkg::PH_MAKE_CALL: begin
							if (timed_out) begin
								emit0 = 1'b1;
								cmd0  = mcs_pkg::CMD_DIAL;
								phase_d = mcs_pkg::PH_IN_CALL;
							end
						end
						mcs_pkg::PH_IN_CALL: begin
							if (timed_out) begin
								emit0 = 1'b1;
								cmd0  = mcs_pkg::CMD_HANGUP;
								phase_d = mcs_pkg::PH_FINISHED;
							end
						end
						mcs_pkg::PH_FINISHED: begin
							emit0 = 1'b1;
							cmd0  = mcs_pkg::CMD_CLOSE_UART;
							phase_d = mcs_pkg::PH_CLEANUP;
						end
						mcs_pkg::PH_CLEANUP: begin
							if (timed_out) begin
								emit0 = 1'b1;
								cmd0  = mcs_pkg::CMD_OPEN_GPS;
								phase_d = mcs_pkg::PH_IDLE;
							end
						end
						default: phase_d = mcs_pkg::PH_IDLE;
					endcase
					// a phase change or a command restarts the counter and drops the receive buffer,
					// except at the end of the call
					if (phase_d != phase_q || emit0) begin
						ms_d = '0;
						if (phase_q != mcs_pkg::PH_IN_CALL && phase_q != mcs_pkg::PH_FINISHED &&
							phase_q != mcs_pkg::PH_CLEANUP) begin
							flags_d = '0;
							pok_d   = 1'b0;
							pcm_d   = '0;
							per_d   = '0;
						end
					end
				end
			end
			mcs_pkg::KIND_BYTE: begin
				if (phase_q != mcs_pkg::PH_IDLE) begin
					pok_d = r_ok[0];
					pcm_d = r_cm[2:0];
					per_d = r_er[2:0];
					flags_d = flags_q
						| (r_ok[3] ? mcs_pkg::FLG_OK : 4'b0000)
						| (r_cm[3] ? mcs_pkg::FLG_CMGS : 4'b0000)
						| (r_er[3] ? mcs_pkg::FLG_ERROR : 4'b0000)
						| ((byte_s1 == mcs_pkg::CHR_PROMPT) ? mcs_pkg::FLG_PROMPT : 4'b0000);
				end
			end
			mcs_pkg::KIND_TRIGGER: begin
				if (phase_q == mcs_pkg::PH_IDLE || phase_q == mcs_pkg::PH_FINISHED) begin
					pos_d   = pos_s1;
					cus_d   = cus_s1;
					sms_d   = 1'b0;
					att_d   = '0;
					flags_d = '0;
					pok_d   = 1'b0;
					pcm_d   = '0;
					per_d   = '0;
					emit0   = 1'b1;
					cmd0    = mcs_pkg::CMD_CLOSE_UART;
					phase_d = mcs_pkg::PH_STARTING;
					ms_d    = '0;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		logic busy;
		busy = (phase_d != mcs_pkg::PH_IDLE) && (phase_d != mcs_pkg::PH_FINISHED);
		push.push             = fire;
		push.two              = emit1;
		push.w0.command       = cmd0;
		push.w0.body_position = (cmd0 == mcs_pkg::CMD_BODY) & pos_q;
		push.w0.body_custom   = (cmd0 == mcs_pkg::CMD_BODY) & cus_q;
		push.w0.busy_res      = busy;
		push.w0.sms_confirmed = sms_d;
		push.w1.command       = cmd1;
		push.w1.body_position = 1'b0;
		push.w1.body_custom   = 1'b0;
		push.w1.busy_res      = busy;
		push.w1.sms_confirmed = sms_d;
	end

endmodule

// ===== src/mcs_outq.sv =====
// Four-word result queue: one or two words in per item, one out per cycle on m_tready.
module mcs_outq (
	input  logic            clk,
	input  logic            arst_n,
	input  mcs_pkg::push_t  push,
	output logic            room,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [7:0]      m_tdata,
	output logic            m_tlast
);

	logic [8:0] mem [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;
	logic [1:0] n_push;
	logic       pop;

	assign m_tvalid = cnt_q != 3'd0;
	assign pop      = m_tvalid & m_tready;
	assign room     = cnt_q <= 3'd2;
	assign n_push   = push.push ? (push.two ? 2'd2 : 2'd1) : 2'd0;
	assign m_tlast  = mem[rd_q][8];
	assign m_tdata  = mem[rd_q][7:0];

	always_ff @(posedge clk) begin
		if (push.push) begin
			mem[wr_q] <= {~push.two, push.w0};
			if (push.two) begin
				mem[wr_q + 2'd1] <= {1'b1, push.w1};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + n_push;
			rd_q  <= rd_q + {1'b0, pop};
			cnt_q <= cnt_q + {1'b0, n_push} - {2'b00, pop};
		end
	end

endmodule

// ===== src/modem_alert_call_sequencer.sv =====
// A word accepted into the input register, once the result queue has room, updates the
// sequence state and writes its result words into the queue, whose head is offered on m_tvalid.
// Throughput: one input word per cycle while the queue has room; an item with two
// results is absorbed by the four-word result queue.
// Reset clears the phase, counters, matcher flags and the queue, and loads the
// configuration registers with their defaults.
module modem_alert_call_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // rx_byte[7:0], has_position, has_custom_text, zero pad
	input  logic [1:0]  s_tuser,   // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // command[3:0], body_position, body_custom, busy_res,
	                               // sms_confirmed
	output logic        m_tlast
);

	mcs_pkg::push_t push;
	logic           room;

	mcs_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata[9:0]),
		.s_tuser   (s_tuser),
		.room      (room),
		.push      (push)
	);

	mcs_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.room     (room),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

// ===== src/mcs_chk.sv =====
// Port-level checker for the alert sequencer, bound to the top level.
`include "modem_alert_call_sequencer_macros.svh"

module mcs_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_we,
	input logic [2:0]  cfg_index,
	input logic [15:0] cfg_wdata,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [15:0] s_tdata,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic        m_tlast
);

	`MCS_ASSERT_NEXT(a_hold_stalled, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result word changed")
	`MCS_ASSERT_NOW(a_body_flags, m_tvalid && (m_tdata[3:0] != mcs_pkg::CMD_BODY), m_tdata[5:4] == 2'b00, "body options outside body command")
	`MCS_ASSERT_NOW(a_open_pairs, m_tvalid && (m_tdata[3:0] == mcs_pkg::CMD_OPEN_MODEM), !m_tlast, "modem open not followed by AT")
	`MCS_ASSERT_NOW(a_gps_ends, m_tvalid && (m_tdata[3:0] == mcs_pkg::CMD_OPEN_GPS), m_tlast && !m_tdata[6], "GPS reopen while still busy")

endmodule

bind modem_alert_call_sequencer mcs_chk u_mcs_chk (.*);
